// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define TTPS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("ttps assertion failed");

// Condition that must never be true outside reset.
`define TTPS_ASSERT_NEVER(label, clk, rst_n, cond) \
  `TTPS_ASSERT(label, clk, rst_n, !(cond))

`endif

// File: hdl/ttps_pkg.sv
// Types and constants of the transposition table probe/store unit.
`default_nettype none

package ttps_pkg;

  // Table holds 2**IDX_W entries; the index is the low IDX_W key bits.
  localparam int unsigned IDX_W         = 16;
  localparam int unsigned TABLE_ENTRIES = 2 ** IDX_W;

  localparam logic [14:0] MATE_THR_RESET = 15'd30000;

  typedef enum logic [1:0] {
    KIND_PROBE = 2'd0,
    KIND_STORE = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  // Reserved bound code is taken as exact.
  typedef enum logic [1:0] {
    BOUND_EXACT = 2'd0,
    BOUND_UPPER = 2'd1,
    BOUND_LOWER = 2'd2,
    BOUND_RSVD  = 2'd3
  } bound_e;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_LOOKUP = 2'd2
  } state_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [63:0]        position_key;
    logic [7:0]         search_depth;
    logic signed [15:0] window_low;
    logic signed [15:0] window_high;
    logic signed [15:0] new_score;
    logic [15:0]        move_word;
    logic [7:0]         ply_count;
    logic [1:0]         bound_kind;
  } ttps_in_t;

  typedef struct packed {
    logic               key_hit;
    logic               usable;
    logic [15:0]        found_move;
    logic signed [15:0] result_score;
    logic [7:0]         found_depth;
    logic [1:0]         found_bound;
    logic [31:0]        filled_count;
  } ttps_out_t;

  typedef struct packed {
    logic [63:0]        key;
    logic signed [15:0] score;
    logic [15:0]        move;
    logic [7:0]         depth;
    logic [1:0]         bound;
  } ttps_entry_t;

  localparam int unsigned ENTRY_W = $bits(ttps_entry_t);

  // Update request from the entry datapath to the control.
  typedef struct packed {
    logic write;
    logic new_key;
  } ttps_upd_t;

endpackage

`default_nettype wire

// File: hdl/ttps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none

module ttps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/ttps_entry_logic.sv
// Probe result and store update computed from one table entry.
`default_nettype none

module ttps_entry_logic (
  input  ttps_pkg::ttps_in_t    req_i,
  input  ttps_pkg::ttps_entry_t entry_i,
  input  logic [14:0]           mate_thr_i,
  input  logic [31:0]           count_i,
  output ttps_pkg::ttps_out_t   result_o,
  output ttps_pkg::ttps_entry_t wr_entry_o,
  output ttps_pkg::ttps_upd_t   upd_o
);

  logic               key_match;
  logic               replace;
  logic [1:0]         bound_n;
  logic signed [16:0] score_ext;
  logic signed [16:0] mate_pos;
  logic signed [16:0] mate_neg;
  logic signed [16:0] adj;
  logic signed [15:0] sat;

  assign key_match = (entry_i.key == req_i.position_key);

  // Reserved bound code is treated as exact.
  assign bound_n = (req_i.bound_kind == ttps_pkg::BOUND_RSVD) ? ttps_pkg::BOUND_EXACT
                                                                : req_i.bound_kind;

  assign replace = !key_match
                || ({1'b0, entry_i.depth} < ({1'b0, req_i.search_depth} + 9'd2))
                || (bound_n == ttps_pkg::BOUND_EXACT);

  // Mate scores move outward by ply, then saturate to 16 bits.
  assign score_ext = 17'(req_i.new_score);
  assign mate_pos  = $signed({2'b00, mate_thr_i});
  assign mate_neg  = -mate_pos;

  always_comb begin
    if (score_ext > mate_pos) begin
      adj = score_ext + $signed({9'd0, req_i.ply_count});
    end else if (score_ext < mate_neg) begin
      adj = score_ext - $signed({9'd0, req_i.ply_count});
    end else begin
      adj = score_ext;
    end
    if (adj > 17'sd32767) begin
      sat = 16'sh7FFF;
    end else if (adj < -17'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = adj[15:0];
    end
  end

  always_comb begin
    wr_entry_o.key   = req_i.position_key;
    wr_entry_o.score = sat;
    wr_entry_o.move  = req_i.move_word;
    wr_entry_o.depth = req_i.search_depth;
    wr_entry_o.bound = bound_n;
  end

  always_comb begin
    result_o = '0;
    upd_o    = '0;
    case (ttps_pkg::kind_e'(req_i.kind))
      ttps_pkg::KIND_PROBE: begin
        if (key_match) begin
          result_o.key_hit    = 1'b1;
          result_o.found_move = entry_i.move;
          if (entry_i.depth >= req_i.search_depth) begin
            result_o.found_depth  = entry_i.depth;
            result_o.found_bound  = entry_i.bound;
            result_o.result_score = entry_i.score;
            result_o.usable       = 1'b1;
            if (entry_i.bound == ttps_pkg::BOUND_UPPER) begin
              if (entry_i.score <= req_i.window_low) begin
                result_o.result_score = req_i.window_low;
              end else begin
                result_o.usable = 1'b0;
              end
            end else if (entry_i.bound == ttps_pkg::BOUND_LOWER) begin
              if (entry_i.score >= req_i.window_high) begin
                result_o.result_score = req_i.window_high;
              end else begin
                result_o.usable = 1'b0;
              end
            end
          end
        end
      end
      ttps_pkg::KIND_STORE: begin
        upd_o.write   = replace;
        upd_o.new_key = !key_match && (count_i != '1);
      end
      default: begin
      end
    endcase
    result_o.filled_count = upd_o.new_key ? (count_i + 32'd1) : count_i;
  end

endmodule

`default_nettype wire

// File: hdl/transposition_table_probe_store_unit.sv
// Top level of the transposition table probe/store unit.
// Direct-mapped search-result table of ttps_pkg::TABLE_ENTRIES entries (65536),
// indexed by the low key bits, held in one RAM with a registered read. A
// probe, store or no-op transaction is accepted in idle, issuing the RAM read;
// the lookup state that follows evaluates the entry, writes it back on a store
// that replaces it and loads the result register, waiting while the output
// cannot take it; the next transaction is accepted only back in idle, as the
// RAM read-modify-write must finish first. A clear transaction zeroes the
// table with a sweep of one entry per cycle and returns its result (count
// zero) at the end of the sweep. The same sweep runs after reset, without a
// result, during which no transaction is accepted; mate_threshold writes are
// taken at all times. Results wait in an output register, so a stalled output
// only holds the block once a second result is ready.
`default_nettype none
`include "assert_macros.svh"

module transposition_table_probe_store_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ttps_pkg::ttps_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ttps_pkg::ttps_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [14:0]         cfg_wdata_i
);

  localparam int unsigned IW = ttps_pkg::IDX_W;

  ttps_pkg::state_e state_q, state_d;

  ttps_pkg::ttps_in_t    req_q;
  ttps_pkg::ttps_out_t   out_q, out_d;
  ttps_pkg::ttps_out_t   calc_result;
  ttps_pkg::ttps_entry_t rd_entry, wr_entry;
  ttps_pkg::ttps_upd_t   upd;

  logic          out_valid_q, out_valid_d;
  logic [14:0]   mate_thr_q;
  logic [31:0]   count_q, count_d;
  logic [IW-1:0] sweep_q, sweep_d;
  logic          clr_reply_q, clr_reply_d;

  logic in_accept;
  logic accept_clear;
  logic out_free;
  logic out_load;
  logic sweep_last;

  logic                       ram_we, ram_re;
  logic [IW-1:0]              ram_waddr;
  logic [ttps_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

  assign in_accept    = in_valid_i && !in_stall_o;
  assign accept_clear = in_accept && (in_data_i.kind == ttps_pkg::KIND_CLEAR);
  assign out_free     = !out_valid_q || !out_stall_i;
  assign sweep_last   = (sweep_q == {IW{1'b1}});

  assign rd_entry = ttps_pkg::ttps_entry_t'(ram_rdata);
  assign ram_wdata = (state_q == ttps_pkg::ST_CLEAR) ? '0 : wr_entry;

  ttps_ram #(
    .WIDTH (ttps_pkg::ENTRY_W),
    .DEPTH (ttps_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (in_data_i.position_key[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  ttps_entry_logic u_entry (
    .req_i      (req_q),
    .entry_i    (rd_entry),
    .mate_thr_i (mate_thr_q),
    .count_i    (count_q),
    .result_o   (calc_result),
    .wr_entry_o (wr_entry),
    .upd_o      (upd)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ttps_pkg::ST_CLEAR: begin
        if (sweep_last && (!clr_reply_q || out_free)) begin
          state_d = ttps_pkg::ST_IDLE;
        end
      end
      ttps_pkg::ST_IDLE: begin
        if (accept_clear) begin
          state_d = ttps_pkg::ST_CLEAR;
        end else if (in_accept) begin
          state_d = ttps_pkg::ST_LOOKUP;
        end
      end
      ttps_pkg::ST_LOOKUP: begin
        if (out_free) begin
          state_d = ttps_pkg::ST_IDLE;
        end
      end
      default: state_d = ttps_pkg::ST_CLEAR;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    in_stall_o  = 1'b1;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = req_q.position_key[IW-1:0];
    out_load    = 1'b0;
    out_d       = out_q;
    count_d     = count_q;
    sweep_d     = sweep_q;
    clr_reply_d = clr_reply_q;
    case (state_q)
      ttps_pkg::ST_CLEAR: begin
        // Hold on the last entry until the clear result can be loaded.
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        if (!sweep_last) begin
          sweep_d = sweep_q + 1'b1;
        end else if (clr_reply_q && out_free) begin
          out_load    = 1'b1;
          out_d       = '0;
          clr_reply_d = 1'b0;
        end
      end
      ttps_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        ram_re     = in_valid_i && !accept_clear;
        if (accept_clear) begin
          count_d     = '0;
          sweep_d     = '0;
          clr_reply_d = 1'b1;
        end
      end
      ttps_pkg::ST_LOOKUP: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = calc_result;
          ram_we   = upd.write;
          count_d  = calc_result.filled_count;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ttps_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
      mate_thr_q  <= ttps_pkg::MATE_THR_RESET;
      count_q     <= '0;
      sweep_q     <= '0;
      clr_reply_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      sweep_q     <= sweep_d;
      clr_reply_q <= clr_reply_d;
      if (cfg_we_i) begin
        mate_thr_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // RAM port use never overlaps: reads only in idle, writes elsewhere.
  `TTPS_ASSERT_NEVER(a_no_rd_wr_overlap, clk_i, rst_ni, ram_we && ram_re)
  // A probe or store goes straight to the lookup state.
  `TTPS_ASSERT(a_accept_to_lookup, clk_i, rst_ni,
               (in_accept && !accept_clear) |=> (state_q == ttps_pkg::ST_LOOKUP))
  // A table update always comes with its result.
  `TTPS_ASSERT(a_write_with_result, clk_i, rst_ni,
               (ram_we && (state_q == ttps_pkg::ST_LOOKUP)) |-> out_load)
  // The fill count drops only after a clear was accepted.
  `TTPS_ASSERT(a_count_drop_on_clear, clk_i, rst_ni,
               (count_q < $past(count_q)) |-> $past(accept_clear))

endmodule

`default_nettype wire
